/* rtl/ett_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ett_pkg
// Shared types, constants and codes for the event timer table.
// ----------------------------------------------------------------------------
package ett_pkg;

    // table geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_IDX_W     = 1;
    localparam int Q_CNT_W     = 2;

    // day arithmetic
    localparam int DAY_S  = 24 * 60 * 60;
    localparam int HOUR_S = 3600;
    localparam int REM_W  = 18;
    localparam int DIV_W  = 33;
    localparam int BIT_W  = 2;

    // day length split as 2^7 * 675, remainder by 675 through a reciprocal
    localparam int          DAY_LOW_W = 7;
    localparam int          DAY_ODD   = 675;
    localparam int          Y_W       = DIV_W - DAY_LOW_W;
    localparam int          RECIP_W   = 27;
    localparam int          RECIP_SH  = 36;
    localparam int          PROD_W    = Y_W + RECIP_W;
    localparam int          QUO_W     = PROD_W - RECIP_SH;
    localparam logic [26:0] DAY_RECIP = 27'd101806632;

    // input commands
    localparam logic [2:0] CMD_ADD_ONCE = 3'd0;
    localparam logic [2:0] CMD_ADD_PER  = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_CLEAR    = 3'd3;
    localparam logic [2:0] CMD_TICK     = 3'd4;

    // classified work kinds
    localparam logic [2:0] K_INVALID  = 3'd0;
    localparam logic [2:0] K_ADD_ONCE = 3'd1;
    localparam logic [2:0] K_ADD_PER  = 3'd2;
    localparam logic [2:0] K_ZERO_PER = 3'd3;
    localparam logic [2:0] K_REMOVE   = 3'd4;
    localparam logic [2:0] K_CLEAR    = 3'd5;
    localparam logic [2:0] K_TICK     = 3'd6;
    localparam logic [2:0] K_NOP      = 3'd7;

    // result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_ZERO_PER  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FIRED     = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;
    localparam logic [2:0] ST_CLK_INV   = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_time;
        logic [31:0] target_time;
        logic [31:0] period_s;
        logic [31:0] event_id;
    } ett_item_t;

    typedef struct packed {
        logic        periodic;
        logic [31:0] start;
        logic [31:0] period;
        logic [31:0] last_run;
        logic [31:0] ident;
    } ett_entry_t;

endpackage
`default_nettype wire

/* rtl/ett_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ett_front
// Accepts input beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ett_front import ett_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic        clock_valid,
    input  wire logic [31:0] now_time,
    input  wire logic [31:0] target_time,
    input  wire logic [31:0] period_s,
    input  wire logic [31:0] event_id,
    output logic             q_valid,
    output ett_item_t        q_item,
    input  wire logic        q_pop
);

    ett_item_t            q_mem [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0]   wr_ptr_reg;
    logic [Q_IDX_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [2:0]           kind;
    logic                 push;
    logic                 pop;

    // classify the incoming beat
    always_comb
    begin
        if (!clock_valid)
        begin
            kind = K_INVALID;
        end
        else
        begin
            unique case (cmd)
                CMD_ADD_ONCE: kind = K_ADD_ONCE;
                CMD_ADD_PER:  kind = (period_s == 32'd0) ? K_ZERO_PER : K_ADD_PER;
                CMD_REMOVE:   kind = K_REMOVE;
                CMD_CLEAR:    kind = K_CLEAR;
                CMD_TICK:     kind = K_TICK;
                default:      kind = K_NOP;
            endcase
        end
    end

    assign in_stall = (cnt_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{kind, now_time, target_time, period_s, event_id};
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/ett_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ett_back
// Executes queued commands against the event table and drives results.
// ----------------------------------------------------------------------------
module ett_back import ett_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        q_valid,
    input  wire ett_item_t   q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      result_id,
    output logic [31:0]      result_time,
    output logic             is_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MOD_A = 3'd2;
    localparam logic [2:0] S_MOD_B = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;

    ett_entry_t         ent_mem [DEPTH];

    logic [2:0]         state_reg, state_next;
    logic [4:0]         tz_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        next_id_reg, next_id_next;
    logic [CNT_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic               found_reg, found_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    ett_item_t          cur_reg, cur_next;
    logic [DIV_W-1:0]   dv_reg, dv_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   an_reg, an_next;
    logic [DIV_W-1:0]   b_reg, b_next;
    logic [REM_W-1:0]   ra_reg, ra_next;
    logic [REM_W-1:0]   rb_reg, rb_next;
    logic               out_valid_reg;
    ett_entry_t         ent_rd_reg;

    logic               out_free;
    logic               emit;
    logic [2:0]         em_status;
    logic [31:0]        em_id;
    logic [31:0]        em_time;
    logic               em_last;
    logic               ent_we;
    logic [IDX_W-1:0]   ent_widx;
    ett_entry_t         ent_wdata;

    logic signed [17:0] tz_ext;
    logic signed [17:0] off_s;
    logic [33:0]        off_ext;
    logic [33:0]        a_sum;
    logic [33:0]        b_sum;
    logic [Y_W-1:0]     dv_hi;
    logic [PROD_W-1:0]  quo_prod;
    logic [QUO_W-1:0]   quo_est;
    logic [Y_W-1:0]     quo_mul;
    logic [Y_W-1:0]     odd_diff;
    logic [REM_W-1:0]   odd_rem;
    logic [REM_W-1:0]   day_rem;
    logic [33:0]        moved;
    logic               due;
    logic               fire;
    logic               match;
    logic               keep;
    logic [31:0]        elapsed;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // zone offset in seconds and the two dividends for the day split
    assign tz_ext  = {{13{tz_reg[4]}}, tz_reg};
    assign off_s   = 18'(tz_ext * 18'sd3600);
    assign off_ext = {{16{off_s[17]}}, off_s};
    assign a_sum   = {2'b00, q_item.now_time} + 34'(DAY_S) + off_ext;
    assign b_sum   = {2'b00, q_item.target_time} + 34'(DAY_S) + off_ext;

    // remainder by the day: low 7 bits pass, upper part reduced by 675
    assign dv_hi    = dv_reg[DIV_W-1:DAY_LOW_W];
    assign quo_prod = PROD_W'(dv_hi) * PROD_W'(DAY_RECIP);
    assign quo_est  = quo_prod[RECIP_SH +: QUO_W];
    assign quo_mul  = Y_W'(quo_reg) * Y_W'(DAY_ODD);
    assign odd_diff = dv_hi - quo_mul;
    assign odd_rem  = (rem_reg >= REM_W'(DAY_ODD)) ? (rem_reg - REM_W'(DAY_ODD)) : rem_reg;
    assign day_rem  = {odd_rem[REM_W-DAY_LOW_W-1:0], dv_reg[DAY_LOW_W-1:0]};

    // start of the next local day plus the target time of day
    assign moved = {1'b0, an_reg} - 34'(ra_reg) + 34'(rb_reg);

    // per-entry decisions while scanning
    assign elapsed = cur_reg.now_time - ent_rd_reg.last_run;
    assign due     = (cur_reg.now_time >= ent_rd_reg.start);
    assign fire    = due && (!ent_rd_reg.periodic || (ent_rd_reg.last_run == 32'd0) ||
                     (elapsed >= ent_rd_reg.period));
    assign match   = !found_reg && (ent_rd_reg.ident == cur_reg.event_id);

    // command sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        next_id_next = next_id_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        found_next   = found_reg;
        bit_next     = bit_reg;
        cur_next     = cur_reg;
        dv_next      = dv_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        an_next      = an_reg;
        b_next       = b_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        em_status    = ST_DONE;
        em_id        = 32'd0;
        em_time      = 32'd0;
        em_last      = 1'b1;
        ent_we       = 1'b0;
        ent_widx     = count_reg[IDX_W-1:0];
        ent_wdata    = ent_rd_reg;
        keep         = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    case (q_item.kind) inside
                        K_INVALID:
                        begin
                            emit      = 1'b1;
                            em_status = ST_CLK_INV;
                        end
                        K_ZERO_PER:
                        begin
                            emit      = 1'b1;
                            em_status = ST_ZERO_PER;
                        end
                        K_CLEAR:
                        begin
                            emit       = 1'b1;
                            em_status  = ST_DONE;
                            count_next = '0;
                        end
                        K_ADD_ONCE, K_ADD_PER:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                emit      = 1'b1;
                                em_status = ST_FULL;
                            end
                            else if (q_item.target_time >= q_item.now_time)
                            begin
                                ent_we       = 1'b1;
                                ent_wdata    = '{(q_item.kind == K_ADD_PER),
                                                 q_item.target_time,
                                                 (q_item.kind == K_ADD_PER) ?
                                                     q_item.period_s : 32'd0,
                                                 32'd0, next_id_reg};
                                emit         = 1'b1;
                                em_status    = ST_ADDED;
                                em_id        = next_id_reg;
                                em_time      = q_item.target_time;
                                count_next   = count_reg + 1'b1;
                                next_id_next = next_id_reg + 32'd1;
                            end
                            else
                            begin
                                an_next    = {1'b0, q_item.now_time} + DIV_W'(DAY_S);
                                dv_next    = a_sum[DIV_W-1:0];
                                b_next     = b_sum[DIV_W-1:0];
                                rem_next   = '0;
                                bit_next   = '0;
                                state_next = S_MOD_A;
                            end
                        end
                        K_REMOVE, K_TICK:
                        begin
                            rd_next    = '0;
                            wr_next    = '0;
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            emit      = 1'b1;
                            em_status = ST_DONE;
                        end
                    endcase
                end
            end

            // three steps: quotient estimate, remainder, final correction
            S_MOD_A, S_MOD_B:
            begin
                if (bit_reg == BIT_W'(0))
                begin
                    quo_next = quo_est;
                    bit_next = BIT_W'(1);
                end
                else if (bit_reg == BIT_W'(1))
                begin
                    rem_next = odd_diff[REM_W-1:0];
                    bit_next = BIT_W'(2);
                end
                else
                begin
                    bit_next = '0;
                    if (state_reg == S_MOD_A)
                    begin
                        ra_next    = day_rem;
                        dv_next    = b_reg;
                        state_next = S_MOD_B;
                    end
                    else
                    begin
                        rb_next    = day_rem;
                        state_next = S_PLACE;
                    end
                end
            end

            S_PLACE:
            begin
                if (out_free)
                begin
                    ent_we       = 1'b1;
                    ent_wdata    = '{(cur_reg.kind == K_ADD_PER), moved[31:0],
                                     (cur_reg.kind == K_ADD_PER) ?
                                         cur_reg.period_s : 32'd0,
                                     32'd0, next_id_reg};
                    emit         = 1'b1;
                    em_status    = ST_ADDED;
                    em_id        = next_id_reg;
                    em_time      = moved[31:0];
                    count_next   = count_reg + 1'b1;
                    next_id_next = next_id_reg + 32'd1;
                    state_next   = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (out_free)
                begin
                    if (rd_reg == count_reg)
                    begin
                        count_next = wr_reg;
                        emit       = 1'b1;
                        if (cur_reg.kind == K_TICK)
                        begin
                            em_status = ST_DONE;
                        end
                        else
                        begin
                            em_status = found_reg ? ST_REMOVED : ST_NOT_FOUND;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // compact in place: kept entries move down to the write slot
                        if (cur_reg.kind == K_TICK)
                        begin
                            keep = !(fire && !ent_rd_reg.periodic);
                            if (fire)
                            begin
                                ent_wdata.last_run = cur_reg.now_time;
                                emit      = 1'b1;
                                em_status = ST_FIRED;
                                em_id     = ent_rd_reg.ident;
                                em_last   = 1'b0;
                            end
                        end
                        else
                        begin
                            keep = !match;
                            if (match)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        if (keep)
                        begin
                            ent_we   = 1'b1;
                            ent_widx = wr_reg[IDX_W-1:0];
                            wr_next  = wr_reg + 1'b1;
                        end
                        rd_next = rd_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table storage; the read follows the next scan slot, which never
    // collides with the compaction write slot
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_widx] <= ent_wdata;
        end
        ent_rd_reg <= ent_mem[rd_next[IDX_W-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tz_reg        <= '0;
            count_reg     <= '0;
            next_id_reg   <= 32'd1;
            rd_reg        <= '0;
            wr_reg        <= '0;
            found_reg     <= 1'b0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            found_reg   <= found_next;
            bit_reg     <= bit_next;
            if (cfg_valid && cfg_ready)
            begin
                tz_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working data and result beat
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        an_reg  <= an_next;
        b_reg   <= b_next;
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        if (emit)
        begin
            status      <= em_status;
            result_id   <= em_id;
            result_time <= em_time;
            is_last     <= em_last;
        end
    end

endmodule
`default_nettype wire

/* rtl/event_timer_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// event_timer_table
// Table of one-shot and periodic timed events with add, remove, clear, tick.
// ----------------------------------------------------------------------------
//  channel  handshake          carries
//  in       in_valid/in_stall  cmd, clock_valid, now_time, target_time,
//                              period_s, event_id
//  out      out_valid/out_stall status, result_id, result_time, is_last
//  cfg      cfg_valid/cfg_ready cfg_data (zone offset in hours, signed)
//
//  most commands give their one result beat in the cycle after leaving the queue
//  tick and remove walk the table one entry a cycle while the result is not stalled
//  an add whose target is past takes the day remainder of now, then of the target
//  a two-beat queue lets inputs land while the table engine is busy
//  reset empties the table and sets the next id to one; no clearing pass
//  a stalled result holds the engine but not the input queue
// ----------------------------------------------------------------------------
module event_timer_table import ett_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic        clock_valid,
    input  wire logic [31:0] now_time,
    input  wire logic [31:0] target_time,
    input  wire logic [31:0] period_s,
    input  wire logic [31:0] event_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      result_id,
    output logic [31:0]      result_time,
    output logic             is_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);

    logic      q_valid;
    logic      q_pop;
    ett_item_t q_item;

    // accept and classify
    ett_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .clock_valid (clock_valid),
        .now_time    (now_time),
        .target_time (target_time),
        .period_s    (period_s),
        .event_id    (event_id),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // table engine
    ett_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .result_id   (result_id),
        .result_time (result_time),
        .is_last     (is_last)
    );

endmodule
`default_nettype wire

/* rtl/ett_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ett_checker
// Port-level checks on the event timer table channels.
// ----------------------------------------------------------------------------
module ett_checker import ett_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [2:0]  cmd,
    input wire logic        clock_valid,
    input wire logic [31:0] now_time,
    input wire logic [31:0] target_time,
    input wire logic [31:0] period_s,
    input wire logic [31:0] event_id,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [31:0] result_id,
    input wire logic [31:0] result_time,
    input wire logic        is_last,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // a stalled input beat stays
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(cmd) && $stable(clock_valid) &&
        $stable(now_time) && $stable(target_time) && $stable(period_s) &&
        $stable(event_id))
        else $error("input beat changed under stall");

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) &&
        $stable(result_id) && $stable(result_time) && $stable(is_last))
        else $error("result beat changed under stall");

    // a firing is never the final beat and carries no time
    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FIRED) |-> !is_last && (result_time == 32'd0))
        else $error("fired beat malformed");

    // only add and fire beats carry an id
    a_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_FIRED) && (status != ST_ADDED) |->
        (result_id == 32'd0) && (result_time == 32'd0) && is_last)
        else $error("status beat carries data");

    // the config port never blocks
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind event_timer_table ett_checker u_ett_checker (.*);
`default_nettype wire
